>>> src/cdo_pkg.sv
// shared types, constants and calendar helpers for the date offset block
// no dependencies

package cdo_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_WALK,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // operation codes
  localparam logic [1:0] OP_DAYS   = 2'd0;
  localparam logic [1:0] OP_MONTHS = 2'd1;
  localparam logic [1:0] OP_YEARS  = 2'd2;

  localparam int MonthsPerYear = 12;
  localparam int LeapCycle     = 400;

  // divisors for the shared compare-subtract unit
  localparam logic [8:0] DIV_YEAR  = 9'(LeapCycle);
  localparam logic [8:0] DIV_MONTH = 9'(MonthsPerYear);

  // biases that make the dividends non-negative (multiples of the divisor)
  localparam int YearBias  = 89 * LeapCycle;       // 35600
  localparam int MonthQ    = 2731;                 // quotient offset
  localparam int MonthBias = MonthQ * MonthsPerYear; // 32772

  // first shift amounts of the restoring loops
  localparam logic [3:0] SH_YEAR  = 4'd7;
  localparam logic [3:0] SH_MONTH = 4'd12;

  typedef struct packed {
    logic [16:0] rem;
    logic [8:0]  base;
    logic [3:0]  sh;
  } div_req_t;

  // leap test from the year residue modulo 400
  function automatic logic leap_of(input logic [8:0] res);
    logic cent;
    cent = (res == 9'd0) || (res == 9'd100) || (res == 9'd200) || (res == 9'd300);
    return ((res[1:0] == 2'd0) && !cent) || (res == 9'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

>>> src/calendar_date_offset.sv
// top level of the gregorian date offset block: sequencer and date registers
// depends on cdo_pkg and cdo_divstep

// Takes one item (op, year_in, month_in, day_in, amount) at a time and returns one
// result item. in_ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next item can be taken while it waits.
// Steps per item; the divisions share one compare-subtract unit:
//   add years  : accept, then load the output register
//   add months : 13 divide-by-12 steps, 8 modulo-400 steps, then the clamp state
//   add days   : 8 modulo-400 steps, then a walk of one month per cycle (up to about 1080
//                months for an amount of 32767 days)
// The month walk keeps the year residue modulo 400 up to date for the leap rule, so
// no divider is needed inside the walk. Month values 0 and 13..15 are taken as 1 and
// 12 for the day and month operations; add years passes month and day through.
// year_overflow flags a final year outside -32768..32767, year_out is its low 16 bits.

module calendar_date_offset (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [15:0] year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [15:0] amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic               year_overflow
);

  cdo_pkg::state_t st, st_next;

  // working registers
  logic [1:0]         opr, opr_next;
  logic signed [17:0] year, year_next;       // exact year, wider than the port
  logic [8:0]         ymod, ymod_next;       // year modulo 400, non-negative
  logic [3:0]         month, month_next;
  logic signed [16:0] day, day_next;         // running day count during the walk
  logic [16:0]        rem, rem_next;
  logic [12:0]        quo, quo_next;
  logic [3:0]         sh, sh_next;

  // shared unit
  cdo_pkg::div_req_t  req;
  logic               ge;
  logic [16:0]        diff;
  logic [16:0]        rem_step;
  logic [12:0]        quo_step;

  // input side helpers
  logic [3:0]         month_c;
  logic signed [18:0] year_bias_in;
  logic signed [17:0] t_bias;

  // walk helpers
  logic [4:0]         len_cur;
  logic [3:0]         pm;
  logic signed [17:0] py;
  logic [8:0]         pymod;
  logic [4:0]         len_prev;
  logic signed [17:0] year_div;
  logic signed [18:0] year_div_bias;
  logic signed [16:0] len_cur_s;

  logic               load_out;

  cdo_divstep u_divstep (
    .req  (req),
    .ge   (ge),
    .diff (diff)
  );

  assign rem_step = ge ? diff : rem;
  assign quo_step = {quo[11:0], ge};

  // month clamp for the day and month operations
  always_comb begin
    if (month_in == 4'd0) begin
      month_c = 4'd1;
    end else if (month_in > 4'd12) begin
      month_c = 4'd12;
    end else begin
      month_c = month_in;
    end
  end

  assign year_bias_in = 19'(year_in) + 19'(cdo_pkg::YearBias);
  // months since january of year_in, biased to stay positive
  assign t_bias = 18'(amount) + $signed({14'd0, month_c}) - 18'sd1
                  + 18'(cdo_pkg::MonthBias);

  // year after the month division, biased for the modulo-400 pass
  assign year_div      = year + $signed({5'd0, quo_step}) - 18'(cdo_pkg::MonthQ);
  assign year_div_bias = 19'(year_div) + 19'(cdo_pkg::YearBias);

  // current month length and the step back to the previous month
  assign len_cur   = cdo_pkg::month_len(month, cdo_pkg::leap_of(ymod));
  assign len_cur_s = $signed({12'd0, len_cur});
  assign pm        = (month == 4'd1) ? 4'd12 : month - 4'd1;
  assign py        = (month == 4'd1) ? year - 18'sd1 : year;
  assign pymod     = (month != 4'd1) ? ymod :
                     (ymod == 9'd0) ? 9'(cdo_pkg::LeapCycle - 1) : ymod - 9'd1;
  assign len_prev  = cdo_pkg::month_len(pm, cdo_pkg::leap_of(pymod));

  assign in_ready = (st == cdo_pkg::ST_IDLE);
  assign load_out = (st == cdo_pkg::ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    req.rem  = rem;
    req.sh   = sh;
    req.base = (st == cdo_pkg::ST_DIV) ? cdo_pkg::DIV_MONTH : cdo_pkg::DIV_YEAR;
  end

  // sequencer: next state and datapath updates
  always_comb begin
    st_next    = st;
    opr_next   = opr;
    year_next  = year;
    ymod_next  = ymod;
    month_next = month;
    day_next   = day;
    rem_next   = rem;
    quo_next   = quo;
    sh_next    = sh;
    case (st)
      cdo_pkg::ST_IDLE: begin
        if (in_valid) begin
          opr_next  = op;
          year_next = 18'(year_in);
          quo_next  = '0;
          case (op)
            cdo_pkg::OP_DAYS: begin
              month_next = month_c;
              day_next   = 17'(amount) + $signed({12'd0, day_in});
              rem_next   = year_bias_in[16:0];
              sh_next    = cdo_pkg::SH_YEAR;
              st_next    = cdo_pkg::ST_MOD;
            end
            cdo_pkg::OP_MONTHS: begin
              month_next = month_c;
              day_next   = $signed({12'd0, day_in});
              rem_next   = t_bias[16:0];
              sh_next    = cdo_pkg::SH_MONTH;
              st_next    = cdo_pkg::ST_DIV;
            end
            default: begin
              // add years, also for the unused code
              year_next  = 18'(year_in) + 18'(amount);
              month_next = month_in;
              day_next   = $signed({12'd0, day_in});
              st_next    = cdo_pkg::ST_DONE;
            end
          endcase
        end
      end
      cdo_pkg::ST_DIV: begin
        rem_next = rem_step;
        quo_next = quo_step;
        sh_next  = sh - 4'd1;
        if (sh == 4'd0) begin
          month_next = rem_step[3:0] + 4'd1;
          year_next  = year_div;
          rem_next   = year_div_bias[16:0];
          sh_next    = cdo_pkg::SH_YEAR;
          st_next    = cdo_pkg::ST_MOD;
        end
      end
      cdo_pkg::ST_MOD: begin
        rem_next = rem_step;
        sh_next  = sh - 4'd1;
        if (sh == 4'd0) begin
          ymod_next = rem_step[8:0];
          st_next   = (opr == cdo_pkg::OP_DAYS) ? cdo_pkg::ST_WALK : cdo_pkg::ST_CLAMP;
        end
      end
      cdo_pkg::ST_WALK: begin
        if (day > len_cur_s) begin
          // forward one month
          day_next = day - len_cur_s;
          if (month == 4'd12) begin
            month_next = 4'd1;
            year_next  = year + 18'sd1;
            ymod_next  = (ymod == 9'(cdo_pkg::LeapCycle - 1)) ? 9'd0 : ymod + 9'd1;
          end else begin
            month_next = month + 4'd1;
          end
        end else if (day <= 17'sd0) begin
          // back one month
          month_next = pm;
          year_next  = py;
          ymod_next  = pymod;
          day_next   = day + $signed({12'd0, len_prev});
        end else begin
          st_next = cdo_pkg::ST_DONE;
        end
      end
      cdo_pkg::ST_CLAMP: begin
        if (day > len_cur_s) begin
          day_next = len_cur_s;
        end else if (day < 17'sd1) begin
          day_next = 17'sd1;
        end
        st_next = cdo_pkg::ST_DONE;
      end
      cdo_pkg::ST_DONE: begin
        if (load_out) begin
          st_next = cdo_pkg::ST_IDLE;
        end
      end
      default: begin
        st_next = cdo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cdo_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    opr   <= opr_next;
    year  <= year_next;
    ymod  <= ymod_next;
    month <= month_next;
    day   <= day_next;
    rem   <= rem_next;
    quo   <= quo_next;
    sh    <= sh_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      year_out      <= year[15:0];
      month_out     <= month;
      day_out       <= day[4:0];
      year_overflow <= (year > 18'sd32767) || (year < -18'sd32768);
    end
  end

  // residue modulo 400 tracks the year during the walk
  a_ymod_low_bits: assert property (@(posedge clk) disable iff (rst)
    st == cdo_pkg::ST_WALK |-> ymod[1:0] == year[1:0])
    else $error("year residue out of step with year");

  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    st == cdo_pkg::ST_WALK |-> ymod < 9'(cdo_pkg::LeapCycle))
    else $error("year residue out of range");

  a_walk_month: assert property (@(posedge clk) disable iff (rst)
    st == cdo_pkg::ST_WALK |-> (month >= 4'd1) && (month <= 4'd12))
    else $error("month out of range during walk");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer did not leave idle after accepting an item");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == cdo_pkg::ST_DONE)
    else $error("result loaded outside the done state");

endmodule

>>> src/cdo_divstep.sv
// shared compare-subtract step of a restoring division
// depends on cdo_pkg

module cdo_divstep (
  input  cdo_pkg::div_req_t req,
  output logic              ge,
  output logic [16:0]       diff
);

  logic [16:0] shifted;

  // divisor aligned to the current quotient bit
  assign shifted = {8'd0, req.base} << req.sh;
  assign ge      = (req.rem >= shifted);
  assign diff    = req.rem - shifted;

endmodule
